// ----- hdl/stl_pkg.sv -----
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types and codes for the sorted term list.
// ----------------------------------------------------------------------------
package stl_pkg;

   localparam int TERM_W = 40;

   localparam logic [1:0] CMD_INSERT   = 2'd0;
   localparam logic [1:0] CMD_DUMP_FWD = 2'd1;
   localparam logic [1:0] CMD_DUMP_REV = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_ENTRY = 2'd2;
   localparam logic [1:0] STAT_EMPTY = 2'd3;

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_INS_RD    = 6'b000010,
      ST_INS_WR    = 6'b000100,
      ST_INS_FIN   = 6'b001000,
      ST_DUMP      = 6'b010000,
      ST_DUMP_TAIL = 6'b100000
   } state_type;

endpackage

// ----- hdl/sorted_term_list_top.sv -----
// ----------------------------------------------------------------------------
// sorted_term_list_top
// Bounded list of polynomial terms kept in ascending x-exponent order.
// ----------------------------------------------------------------------------
// Items are taken while busy is low; results leave on rsp_strobe, one per
// cycle, and cannot be stalled. Entries sit in one memory with registered
// read data. An insert at the end of the list (or into an empty list), a
// rejected insert and an empty dump complete from idle, the result showing
// in the next cycle. Any other insert moves each entry above its slot up by
// one, a read and a write per entry, with busy high until the new term is
// written. A dump keeps busy high while it streams one entry per cycle from
// the memory read port.
module sorted_term_list_top #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic signed [15:0] req_term_coef,
   input  logic [7:0]         req_term_x_exp,
   input  logic [7:0]         req_term_y_exp,
   input  logic [7:0]         req_term_z_exp,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic signed [15:0] rsp_out_coef,
   output logic [7:0]         rsp_out_x_exp,
   output logic [7:0]         rsp_out_y_exp,
   output logic [7:0]         rsp_out_z_exp,
   output logic               rsp_last
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [stl_pkg::TERM_W-1:0] term_mem_ff [DEPTH];
   logic [stl_pkg::TERM_W-1:0] rd_data_ff;

   stl_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] left_ff, left_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [7:0]    head_ff, head_in;
   logic [7:0]    tail_ff, tail_in;
   logic          front_ff, front_in;
   logic          dir_rev_ff, dir_rev_in;
   logic [stl_pkg::TERM_W-1:0] new_ff, new_in;
   logic          pend_ff, pend_in;
   logic          pend_last_ff, pend_last_in;
   logic          stat_vld_ff, stat_vld_in;
   logic [1:0]    stat_ff, stat_in;

   logic                       mem_we;
   logic [AW-1:0]              mem_wa;
   logic [stl_pkg::TERM_W-1:0] mem_wd;
   logic [AW-1:0]              rd_addr;

   logic [stl_pkg::TERM_W-1:0] req_term;
   logic                       key_front;
   logic                       key_back;

   assign req_term  = {req_term_coef, req_term_x_exp, req_term_y_exp, req_term_z_exp};
   assign key_front = (count_ff == '0) || (req_term_x_exp <= head_ff);
   assign key_back  = !key_front && (req_term_x_exp >= tail_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      left_in      = left_ff;
      ptr_in       = ptr_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      front_in     = front_ff;
      dir_rev_in   = dir_rev_ff;
      new_in       = new_ff;
      pend_in      = 1'b0;
      pend_last_in = 1'b0;
      stat_vld_in  = 1'b0;
      stat_in      = stat_ff;
      mem_we       = 1'b0;
      mem_wa       = ptr_ff;
      mem_wd       = new_ff;
      rd_addr      = ptr_ff;

      unique case (state_ff)
         stl_pkg::ST_IDLE: begin
            if (start) begin
               priority case (req_cmd)
                  stl_pkg::CMD_INSERT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        stat_vld_in = 1'b1;
                        stat_in     = stl_pkg::STAT_FULL;
                     end else if ((count_ff == '0) || key_back) begin
                        mem_we      = 1'b1;
                        mem_wa      = count_ff[AW-1:0];
                        mem_wd      = req_term;
                        count_in    = count_ff + CW'(1);
                        if (count_ff == '0) begin
                           head_in = req_term_x_exp;
                        end
                        tail_in     = req_term_x_exp;
                        stat_vld_in = 1'b1;
                        stat_in     = stl_pkg::STAT_OK;
                     end else begin
                        new_in   = req_term;
                        front_in = key_front;
                        ptr_in   = count_ff[AW-1:0];
                        state_in = stl_pkg::ST_INS_RD;
                     end
                  end
                  stl_pkg::CMD_DUMP_FWD, stl_pkg::CMD_DUMP_REV: begin
                     if (count_ff == '0) begin
                        stat_vld_in = 1'b1;
                        stat_in     = stl_pkg::STAT_EMPTY;
                     end else begin
                        dir_rev_in = (req_cmd == stl_pkg::CMD_DUMP_REV);
                        ptr_in     = (req_cmd == stl_pkg::CMD_DUMP_REV) ?
                                     AW'(count_ff - CW'(1)) : '0;
                        left_in    = count_ff;
                        state_in   = stl_pkg::ST_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         stl_pkg::ST_INS_RD: begin
            rd_addr  = ptr_ff - AW'(1);
            state_in = stl_pkg::ST_INS_WR;
         end
         stl_pkg::ST_INS_WR: begin
            mem_we = 1'b1;
            if (front_ff || (rd_data_ff[23:16] >= new_ff[23:16])) begin
               mem_wd   = rd_data_ff;
               ptr_in   = ptr_ff - AW'(1);
               state_in = (ptr_ff == AW'(1)) ? stl_pkg::ST_INS_FIN : stl_pkg::ST_INS_RD;
            end else begin
               count_in    = count_ff + CW'(1);
               stat_vld_in = 1'b1;
               stat_in     = stl_pkg::STAT_OK;
               state_in    = stl_pkg::ST_IDLE;
            end
         end
         stl_pkg::ST_INS_FIN: begin
            mem_we      = 1'b1;
            count_in    = count_ff + CW'(1);
            head_in     = new_ff[23:16];
            stat_vld_in = 1'b1;
            stat_in     = stl_pkg::STAT_OK;
            state_in    = stl_pkg::ST_IDLE;
         end
         stl_pkg::ST_DUMP: begin
            pend_in      = 1'b1;
            pend_last_in = (left_ff == CW'(1));
            left_in      = left_ff - CW'(1);
            ptr_in       = dir_rev_ff ? ptr_ff - AW'(1) : ptr_ff + AW'(1);
            if (left_ff == CW'(1)) begin
               state_in = stl_pkg::ST_DUMP_TAIL;
            end
         end
         stl_pkg::ST_DUMP_TAIL: begin
            state_in = stl_pkg::ST_IDLE;
         end
         default: begin
            state_in = stl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         term_mem_ff[mem_wa] <= mem_wd;
      end
      rd_data_ff <= term_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= stl_pkg::ST_IDLE;
         count_ff    <= '0;
         pend_ff     <= 1'b0;
         stat_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         pend_ff     <= pend_in;
         stat_vld_ff <= stat_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff      <= left_in;
      ptr_ff       <= ptr_in;
      head_ff      <= head_in;
      tail_ff      <= tail_in;
      front_ff     <= front_in;
      dir_rev_ff   <= dir_rev_in;
      new_ff       <= new_in;
      pend_last_ff <= pend_last_in;
      stat_ff      <= stat_in;
   end

   assign busy          = (state_ff != stl_pkg::ST_IDLE);
   assign rsp_strobe    = pend_ff || stat_vld_ff;
   assign rsp_status    = pend_ff ? stl_pkg::STAT_ENTRY : stat_ff;
   assign rsp_out_coef  = pend_ff ? rd_data_ff[39:24] : '0;
   assign rsp_out_x_exp = pend_ff ? rd_data_ff[23:16] : '0;
   assign rsp_out_y_exp = pend_ff ? rd_data_ff[15:8] : '0;
   assign rsp_out_z_exp = pend_ff ? rd_data_ff[7:0] : '0;
   assign rsp_last      = pend_ff ? pend_last_ff : 1'b1;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("term count above depth");

   a_one_source: assert property (@(posedge clock) disable iff (reset)
      !(pend_ff && stat_vld_ff))
      else $error("entry and status result in the same cycle");

   a_full_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == stl_pkg::CMD_INSERT) && (count_ff == CW'(DEPTH)))
      |=> (rsp_strobe && (rsp_status == stl_pkg::STAT_FULL) && $stable(count_ff)))
      else $error("insert into full list not rejected");

   a_no_write_in_dump: assert property (@(posedge clock) disable iff (reset)
      (state_ff == stl_pkg::ST_DUMP) |-> !mem_we)
      else $error("memory write during dump");

endmodule

// ----- tb/sorted_term_list_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_term_list_checker
// Watches the request and response ports of the sorted term list, keeps its
// own ordered copy of the stored terms, and checks every response field
// against the answers due, oldest first. Reports mismatches and the number of
// answers still outstanding.
// ----------------------------------------------------------------------------
module sorted_term_list_checker #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic signed [15:0] req_term_coef,
   input  logic [7:0]         req_term_x_exp,
   input  logic [7:0]         req_term_y_exp,
   input  logic [7:0]         req_term_z_exp,
   input  logic               rsp_strobe,
   input  logic [1:0]         rsp_status,
   input  logic signed [15:0] rsp_out_coef,
   input  logic [7:0]         rsp_out_x_exp,
   input  logic [7:0]         rsp_out_y_exp,
   input  logic [7:0]         rsp_out_z_exp,
   input  logic               rsp_last,
   output int                 fail_count,
   output int                 results_due
);

   typedef struct packed {
      logic signed [15:0] coef;
      logic [7:0]         x_exp;
      logic [7:0]         y_exp;
      logic [7:0]         z_exp;
   } term_type;

   typedef struct packed {
      logic [1:0] status;
      term_type   term;
      logic       last;
   } answer_type;

   term_type   held_terms [DEPTH];
   int         held_count = 0;
   answer_type due_answers [$];
   int         mismatches = 0;

   // front if key <= first, end if key >= last, else before first key >= new
   function automatic int insert_slot(input logic [7:0] key);
      int slot;
      slot = held_count;
      if (held_count == 0 || key <= held_terms[0].x_exp) begin
         slot = 0;
      end else if (key >= held_terms[held_count - 1].x_exp) begin
         slot = held_count;
      end else begin
         for (int i = held_count - 1; i >= 1; i--) begin
            if (held_terms[i].x_exp >= key) slot = i;
         end
      end
      return slot;
   endfunction

   task automatic apply_list_command(input logic [1:0] cmd, input term_type fresh);
      answer_type ans;
      int         slot;
      ans = '0;
      unique case (cmd)
         stl_pkg::CMD_INSERT: begin
            ans.last = 1'b1;
            if (held_count >= DEPTH) begin
               ans.status = stl_pkg::STAT_FULL;
            end else begin
               slot = insert_slot(fresh.x_exp);
               for (int i = held_count; i > slot; i--) held_terms[i] = held_terms[i - 1];
               held_terms[slot] = fresh;
               held_count++;
               ans.status = stl_pkg::STAT_OK;
            end
            due_answers.push_back(ans);
         end
         stl_pkg::CMD_DUMP_FWD, stl_pkg::CMD_DUMP_REV: begin
            if (held_count == 0) begin
               ans.status = stl_pkg::STAT_EMPTY;
               ans.last   = 1'b1;
               due_answers.push_back(ans);
            end else begin
               for (int i = 0; i < held_count; i++) begin
                  ans.status = stl_pkg::STAT_ENTRY;
                  ans.term   = held_terms[(cmd == stl_pkg::CMD_DUMP_FWD) ?
                                          i : held_count - 1 - i];
                  ans.last   = (i == held_count - 1);
                  due_answers.push_back(ans);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string fname, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", fname, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      answer_type want;
      term_type   fresh;
      if (!reset) begin
         if (rsp_strobe) begin
            if (due_answers.size() == 0) begin
               $error("unexpected result: status %0d last %0d", rsp_status, rsp_last);
               mismatches++;
            end else begin
               want = due_answers.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("out_coef", want.term.coef, rsp_out_coef);
               check_field("out_x_exp", want.term.x_exp, rsp_out_x_exp);
               check_field("out_y_exp", want.term.y_exp, rsp_out_y_exp);
               check_field("out_z_exp", want.term.z_exp, rsp_out_z_exp);
               check_field("last", want.last, rsp_last);
            end
         end
         if (start && !busy) begin
            fresh.coef  = req_term_coef;
            fresh.x_exp = req_term_x_exp;
            fresh.y_exp = req_term_y_exp;
            fresh.z_exp = req_term_z_exp;
            apply_list_command(req_cmd, fresh);
         end
      end
      fail_count  <= mismatches;
      results_due <= due_answers.size();
   end

endmodule

// ----- tb/sorted_term_list_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_term_list_top_test
// Stimulus and verdict for the sorted term list.
// Directed items cover empty dumps, the ignored command, front, end, middle
// and equal-key inserts; random items then fill the list, hit the full case
// and dump it both ways, with the request side idling in phases.
// ----------------------------------------------------------------------------
module sorted_term_list_top_test;

   localparam int         LIST_DEPTH   = 16;
   localparam int         ITEM_TARGET  = 364;
   localparam int         CYCLE_LIMIT  = 300000;
   localparam int         DRAIN_CYCLES = 2 * LIST_DEPTH + 8;
   localparam int         MAX_GAP      = 40;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_cmd = stl_pkg::CMD_INSERT;
   logic signed [15:0] req_term_coef = '0;
   logic [7:0]         req_term_x_exp = '0;
   logic [7:0]         req_term_y_exp = '0;
   logic [7:0]         req_term_z_exp = '0;
   logic               rsp_strobe;
   logic [1:0]         rsp_status;
   logic signed [15:0] rsp_out_coef;
   logic [7:0]         rsp_out_x_exp;
   logic [7:0]         rsp_out_y_exp;
   logic [7:0]         rsp_out_z_exp;
   logic               rsp_last;

   int fail_count;
   int results_due;
   int cycle_count     = 0;
   int sender_idle_pct = 0;

   always #2 clock = ~clock;

   sorted_term_list_top #(.DEPTH(LIST_DEPTH)) uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_term_coef  (req_term_coef),
      .req_term_x_exp (req_term_x_exp),
      .req_term_y_exp (req_term_y_exp),
      .req_term_z_exp (req_term_z_exp),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_out_coef   (rsp_out_coef),
      .rsp_out_x_exp  (rsp_out_x_exp),
      .rsp_out_y_exp  (rsp_out_y_exp),
      .rsp_out_z_exp  (rsp_out_z_exp),
      .rsp_last       (rsp_last)
   );

   sorted_term_list_checker #(.DEPTH(LIST_DEPTH)) list_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_term_coef  (req_term_coef),
      .req_term_x_exp (req_term_x_exp),
      .req_term_y_exp (req_term_y_exp),
      .req_term_z_exp (req_term_z_exp),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_out_coef   (rsp_out_coef),
      .rsp_out_x_exp  (rsp_out_x_exp),
      .rsp_out_y_exp  (rsp_out_y_exp),
      .rsp_out_z_exp  (rsp_out_z_exp),
      .rsp_last       (rsp_last),
      .fail_count     (fail_count),
      .results_due    (results_due)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // returns at the edge where the item is taken
   task automatic send_item(input logic [1:0] cmd, input logic signed [15:0] coef,
                            input logic [7:0] x_exp, input logic [7:0] y_exp,
                            input logic [7:0] z_exp);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_cmd        <= cmd;
      req_term_coef  <= coef;
      req_term_x_exp <= x_exp;
      req_term_y_exp <= y_exp;
      req_term_z_exp <= z_exp;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      int         sent;
      int         pick;
      logic [1:0] cmd;
      logic [7:0] key;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty dumps, ignored command, placement rules, equal keys
      send_item(stl_pkg::CMD_DUMP_FWD, 16'sd0, 8'd0, 8'd0, 8'd0);
      send_item(stl_pkg::CMD_DUMP_REV, -16'sd1, 8'hff, 8'hff, 8'hff);
      send_item(CMD_UNUSED, 16'sd5, 8'd9, 8'd9, 8'd9);
      send_item(stl_pkg::CMD_DUMP_FWD, 16'sd0, 8'd0, 8'd0, 8'd0);
      send_item(stl_pkg::CMD_INSERT, 16'sh8000, 8'd128, 8'd0, 8'd255);
      send_item(stl_pkg::CMD_INSERT, 16'sd32767, 8'd0, 8'd255, 8'd0);
      send_item(stl_pkg::CMD_INSERT, -16'sd1, 8'd255, 8'd170, 8'd85);
      send_item(stl_pkg::CMD_INSERT, 16'sd1, 8'd128, 8'd85, 8'd170);
      send_item(stl_pkg::CMD_INSERT, 16'sd2, 8'd0, 8'd1, 8'd2);
      send_item(stl_pkg::CMD_INSERT, 16'sd3, 8'd255, 8'd3, 8'd4);
      send_item(stl_pkg::CMD_DUMP_FWD, 16'sd0, 8'd0, 8'd0, 8'd0);
      send_item(stl_pkg::CMD_INSERT, 16'sd4, 8'd64, 8'd5, 8'd6);
      send_item(stl_pkg::CMD_INSERT, 16'sd0, 8'd200, 8'd0, 8'd0);
      send_item(stl_pkg::CMD_INSERT, -16'sd200, 8'd127, 8'd254, 8'd1);
      send_item(stl_pkg::CMD_DUMP_FWD, 16'sd0, 8'd0, 8'd0, 8'd0);
      send_item(stl_pkg::CMD_DUMP_REV, 16'sd0, 8'd0, 8'd0, 8'd0);

      sent = 0;
      while (sent < ITEM_TARGET) begin
         case ((sent / 8) % 3)
            0: begin
               sender_idle_pct = 0;
            end
            1: begin
               sender_idle_pct = 78;
            end
            default: begin
               sender_idle_pct = 14;
            end
         endcase
         pick = $urandom_range(0, 99);
         if (pick < 45) cmd = stl_pkg::CMD_INSERT;
         else if (pick < 70) cmd = stl_pkg::CMD_DUMP_FWD;
         else if (pick < 94) cmd = stl_pkg::CMD_DUMP_REV;
         else cmd = CMD_UNUSED;
         // narrow keys half the time so equal keys show up
         if ($urandom_range(0, 1) == 0) key = 8'($urandom_range(0, 7));
         else key = 8'($urandom);
         send_item(cmd, 16'($urandom), key, 8'($urandom), 8'($urandom));
         sent++;
      end

      start <= 1'b0;
      do @(posedge clock); while (results_due != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
